>>> src/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types, codes and helpers for the escape-time fractal pixel unit.
// ----------------------------------------------------------------------------
package etf_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned INDEX_W = 9;
    localparam int unsigned ITER_W  = 8;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Palette divider widths: numerators stay below 2^18, divisors below 2^10.
    localparam int unsigned NUM_W = 18;
    localparam int unsigned DEN_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND      = 3'd0,
        REG_LIMIT     = 3'd1,
        REG_JULIA_RE  = 3'd2,
        REG_JULIA_IM  = 3'd3,
        REG_ORIGIN_RE = 3'd4,
        REG_ORIGIN_IM = 3'd5,
        REG_STEP_RE   = 3'd6,
        REG_STEP_IM   = 3'd7
    } etf_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_SETUP,
        ST_DIV,
        ST_OUT
    } etf_state_t;

    // One mapped pixel waiting between the front and the back.
    typedef struct packed {
        logic [INDEX_W-1:0]        col;
        logic [INDEX_W-1:0]        row;
        logic signed [COORD_W-1:0] pr;
        logic signed [COORD_W-1:0] pi;
    } etf_item_t;

    // Saturate a signed value to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sh0000_7FFF_FFFF;
        lo = -48'sh0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return -32'sh8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

>>> src/etf_front.sv
// ----------------------------------------------------------------------------
// etf_front
// Accepts grid positions, maps them to Q4.28 points and queues them.
// ----------------------------------------------------------------------------
module etf_front
    import etf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [INDEX_W-1:0]        column,
    input  logic [INDEX_W-1:0]        row,
    input  logic signed [COORD_W-1:0] origin_re,
    input  logic signed [COORD_W-1:0] origin_im,
    input  logic [30:0]               step_re,
    input  logic [30:0]               step_im,
    output logic                      q_valid,
    output etf_item_t                 q_item,
    input  logic                      q_pop
);

    localparam int unsigned DEPTH = 2;

    logic                 st_valid_reg;
    logic [INDEX_W-1:0]   st_col_reg;
    logic [INDEX_W-1:0]   st_row_reg;
    logic [39:0]          prod_re_reg;
    logic [39:0]          prod_im_reg;

    etf_item_t            mem [DEPTH];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;

    logic                 accept;
    etf_item_t            push_item;
    logic signed [47:0]   sum_re;
    logic signed [47:0]   sum_im;

    // A staged item always finds a free slot, because busy counts it.
    assign busy   = (count_reg + {1'b0, st_valid_reg}) >= 2'(DEPTH);
    assign accept = start && !busy;

    assign sum_re = 48'(origin_re) + $signed({8'd0, prod_re_reg});
    assign sum_im = 48'(origin_im) + $signed({8'd0, prod_im_reg});

    always_comb
    begin
        push_item.col = st_col_reg;
        push_item.row = st_row_reg;
        push_item.pr  = sat32(sum_re);
        push_item.pi  = sat32(sum_im);
    end

    always_comb
    begin
        count_next = count_reg;
        if (st_valid_reg && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!st_valid_reg && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_valid_reg <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end else begin
            st_valid_reg <= accept;
            count_reg    <= count_next;
            if (st_valid_reg) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            st_col_reg  <= column;
            st_row_reg  <= row;
            prod_re_reg <= 40'(column) * 40'(step_re);
            prod_im_reg <= 40'(row) * 40'(step_im);
        end
        if (st_valid_reg) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign q_valid = count_reg != 2'd0;
    assign q_item  = mem[rd_ptr_reg];

endmodule

>>> src/etf_back.sv
// ----------------------------------------------------------------------------
// etf_back
// Runs the z = z^2 + c iteration for one point and forms its palette color.
// ----------------------------------------------------------------------------
module etf_back
    import etf_pkg::*;
#(
    parameter int unsigned LIMIT_CAP = 255
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  etf_item_t                 q_item,
    output logic                      q_pop,
    input  logic                      kind,
    input  logic [ITER_W-1:0]         limit,
    input  logic signed [COORD_W-1:0] julia_re,
    input  logic signed [COORD_W-1:0] julia_im,
    output logic                      done,
    output logic [INDEX_W-1:0]        out_column,
    output logic [INDEX_W-1:0]        out_row,
    output logic                      drawn,
    output logic [ITER_W-1:0]         iterations,
    output logic [COLOR_W-1:0]        red,
    output logic [COLOR_W-1:0]        green,
    output logic [COLOR_W-1:0]        blue
);

    localparam logic [ITER_W-1:0] CAP = ITER_W'((LIMIT_CAP > 255) ? 255 : LIMIT_CAP);
    localparam logic [63:0] FOUR = 64'd1 << 58;
    localparam int unsigned LANES = 3;

    etf_state_t state_reg;
    etf_state_t state_next;

    etf_item_t                 item_reg;
    logic                      kind_reg;
    logic [ITER_W-1:0]         limit_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [COORD_W-1:0] zr_reg;
    logic signed [COORD_W-1:0] zi_reg;
    logic signed [COORD_W-1:0] cr_reg;
    logic signed [COORD_W-1:0] ci_reg;
    logic signed [63:0]        sr_reg;
    logic signed [63:0]        si_reg;
    logic signed [63:0]        cross_reg;
    logic                      drawn_reg;
    logic [4:0]                cnt_reg;

    logic [NUM_W-1:0] num_reg [LANES];
    logic [DEN_W-1:0] den_reg [LANES];
    logic [DEN_W-1:0] rem_reg [LANES];
    logic [NUM_W-1:0] quo_reg [LANES];

    logic [63:0]        mag;
    logic signed [63:0] diff;
    logic signed [63:0] dsh;
    logic signed [63:0] csh;
    logic [NUM_W-1:0]   li;
    logic [NUM_W-1:0]   ii;
    logic [ITER_W-1:0]  col8 [LANES];

    assign mag  = 64'(sr_reg) + 64'(si_reg);
    assign diff = sr_reg - si_reg;
    assign dsh  = diff >>> 28;
    assign csh  = cross_reg >>> 27;
    assign li   = NUM_W'(limit_reg);
    assign ii   = NUM_W'(iter_reg);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   state_next = (iter_reg < limit_reg) ? ST_ADD : ST_SETUP;
            ST_ADD:   state_next = (mag > FOUR) ? ST_SETUP : ST_MUL;
            ST_SETUP: state_next = (iter_reg < limit_reg) ? ST_DIV : ST_OUT;
            ST_DIV:   state_next = (cnt_reg == 5'd1) ? ST_OUT : ST_DIV;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg  <= q_item;
                kind_reg  <= kind;
                limit_reg <= (limit > CAP) ? CAP : limit;
            end
            ST_LOAD:
            begin
                iter_reg <= '0;
                if (kind_reg) begin
                    zr_reg <= item_reg.pr;
                    zi_reg <= item_reg.pi;
                    cr_reg <= julia_re;
                    ci_reg <= julia_im;
                end else begin
                    zr_reg <= '0;
                    zi_reg <= '0;
                    cr_reg <= item_reg.pr;
                    ci_reg <= item_reg.pi;
                end
            end
            ST_MUL:
            begin
                sr_reg    <= zr_reg * zr_reg;
                si_reg    <= zi_reg * zi_reg;
                cross_reg <= zr_reg * zi_reg;
            end
            ST_ADD:
            begin
                if (mag <= FOUR) begin
                    zr_reg   <= sat32(48'(dsh) + 48'(cr_reg));
                    zi_reg   <= sat32(48'(csh) + 48'(ci_reg));
                    iter_reg <= iter_reg + 1'b1;
                end
            end
            ST_SETUP:
            begin
                drawn_reg <= iter_reg < limit_reg;
                cnt_reg   <= 5'(NUM_W);
                for (int k = 0; k < LANES; k++) begin
                    rem_reg[k] <= '0;
                    quo_reg[k] <= '0;
                end
                if (kind_reg) begin
                    num_reg[0] <= NUM_W'(102) * li + NUM_W'(357) * ii;
                    num_reg[1] <= NUM_W'(459) * ii;
                    num_reg[2] <= NUM_W'(204) * li - NUM_W'(102) * ii;
                    den_reg[0] <= {1'b0, limit_reg, 1'b0};
                    den_reg[1] <= {1'b0, limit_reg, 1'b0};
                    den_reg[2] <= {2'b00, limit_reg};
                end else begin
                    num_reg[0] <= NUM_W'(204) * ii;
                    num_reg[1] <= NUM_W'(459) * li - NUM_W'(408) * ii;
                    num_reg[2] <= NUM_W'(918) * li + NUM_W'(51) * ii;
                    den_reg[0] <= {2'b00, limit_reg};
                    den_reg[1] <= {1'b0, limit_reg, 1'b0};
                    den_reg[2] <= {limit_reg, 2'b00};
                end
            end
            ST_DIV:
            begin
                // One restoring division step per lane and cycle.
                cnt_reg <= cnt_reg - 5'd1;
                for (int k = 0; k < LANES; k++) begin
                    if ({rem_reg[k], num_reg[k][NUM_W-1]} >= {1'b0, den_reg[k]}) begin
                        rem_reg[k] <= DEN_W'({rem_reg[k], num_reg[k][NUM_W-1]}
                                             - {1'b0, den_reg[k]});
                        quo_reg[k] <= {quo_reg[k][NUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg[k] <= DEN_W'({rem_reg[k], num_reg[k][NUM_W-1]});
                        quo_reg[k] <= {quo_reg[k][NUM_W-2:0], 1'b0};
                    end
                    num_reg[k] <= {num_reg[k][NUM_W-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++) begin
            if (!drawn_reg) begin
                col8[k] = '0;
            end else if (|quo_reg[k][NUM_W-1:COLOR_W]) begin
                col8[k] = '1;
            end else begin
                col8[k] = quo_reg[k][COLOR_W-1:0];
            end
        end
    end

    assign done       = state_reg == ST_OUT;
    assign out_column = item_reg.col;
    assign out_row    = item_reg.row;
    assign drawn      = drawn_reg;
    assign iterations = iter_reg;
    assign red        = col8[0];
    assign green      = col8[1];
    assign blue       = col8[2];

    a_iter_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD |-> iter_reg < limit_reg)
        else $error("iteration runs past the limit");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from an empty queue");

    a_blank_undrawn: assert property (@(posedge clk) disable iff (!rst_n)
        done && !drawn |-> red == '0 && green == '0 && blue == '0)
        else $error("undrawn pixel carries a color");

    a_drawn_escaped: assert property (@(posedge clk) disable iff (!rst_n)
        done && drawn |-> iterations < limit_reg)
        else $error("drawn pixel did not escape");

endmodule

>>> src/escape_time_fractal_pixel_unit.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit
// Mandelbrot / Julia escape-time pixel engine with a linear palette.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start, busy             column, row
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data
//  result    done (one-cycle strobe) out_column, out_row, drawn, iterations,
//                                    red, green, blue
//
// The front maps an item into a staging register and queues it (two entries, busy
// while full). The back runs each iteration as a multiply state and an add-and-test
// state. A pixel that escapes goes through the 18-step palette divider; one reaching
// the limit L skips the divider. Reset loads the documented register defaults.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_unit
    import etf_pkg::*;
#(
    parameter int unsigned MAX_ITERATION_LIMIT = 255
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [INDEX_W-1:0]        column,
    input  logic [INDEX_W-1:0]        row,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                      done,
    output logic [INDEX_W-1:0]        out_column,
    output logic [INDEX_W-1:0]        out_row,
    output logic                      drawn,
    output logic [ITER_W-1:0]         iterations,
    output logic [COLOR_W-1:0]        red,
    output logic [COLOR_W-1:0]        green,
    output logic [COLOR_W-1:0]        blue
);

    logic                      kind_reg;
    logic [ITER_W-1:0]         limit_reg;
    logic signed [COORD_W-1:0] julia_re_reg;
    logic signed [COORD_W-1:0] julia_im_reg;
    logic signed [COORD_W-1:0] origin_re_reg;
    logic signed [COORD_W-1:0] origin_im_reg;
    logic [30:0]               step_re_reg;
    logic [30:0]               step_im_reg;

    logic      q_valid;
    logic      q_pop;
    etf_item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg      <= 1'b0;
            limit_reg     <= 8'd80;
            julia_re_reg  <= -32'sd187904819;
            julia_im_reg  <= 32'sd72520065;
            origin_re_reg <= -32'sd536870912;
            origin_im_reg <= -32'sd322122547;
            step_re_reg   <= 31'd2018312;
            step_im_reg   <= 31'd2154665;
        end else if (cfg_valid && cfg_ready) begin
            case (etf_reg_t'(cfg_index))
                REG_KIND:      kind_reg      <= cfg_data[0];
                REG_LIMIT:     limit_reg     <= cfg_data[ITER_W-1:0];
                REG_JULIA_RE:  julia_re_reg  <= cfg_data;
                REG_JULIA_IM:  julia_im_reg  <= cfg_data;
                REG_ORIGIN_RE: origin_re_reg <= cfg_data;
                REG_ORIGIN_IM: origin_im_reg <= cfg_data;
                REG_STEP_RE:   step_re_reg   <= cfg_data[30:0];
                REG_STEP_IM:   step_im_reg   <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    etf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .column    (column),
        .row       (row),
        .origin_re (origin_re_reg),
        .origin_im (origin_im_reg),
        .step_re   (step_re_reg),
        .step_im   (step_im_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    etf_back #(
        .LIMIT_CAP (MAX_ITERATION_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .kind       (kind_reg),
        .limit      (limit_reg),
        .julia_re   (julia_re_reg),
        .julia_im   (julia_im_reg),
        .done       (done),
        .out_column (out_column),
        .out_row    (out_row),
        .drawn      (drawn),
        .iterations (iterations),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule
